>>> hw/rtl/allfp_pkg.sv
// ----------------------------------------------------------------------------
// allfp_pkg
// Command, status and field definitions shared by the free pool list block.
// ----------------------------------------------------------------------------
package allfp_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SLOT_W = 6;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam cmd_t CMD_AFTER  = 3'd0;
  localparam cmd_t CMD_BEFORE = 3'd1;
  localparam cmd_t CMD_HEAD   = 3'd2;
  localparam cmd_t CMD_TAIL   = 3'd3;
  localparam cmd_t CMD_DEL    = 3'd4;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_ABSENT = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

endpackage

>>> hw/rtl/allfp_ram.sv
// ----------------------------------------------------------------------------
// allfp_ram
// Generic simple dual port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module allfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/array_linked_list_free_pool.sv
// ----------------------------------------------------------------------------
// array_linked_list_free_pool
// Doubly linked list in slot memories with a sentinel and a free slot chain.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. An insert runs the
// states RD1, RD2 and WR, a delete RD1 and WR and a rejected command RD1 alone
// before busy falls; the states follow the dependent link reads through the
// single read port of the forward link memory, each read registered. The
// result shows for one cycle with done_o high, rising at the same edge at
// which busy falls, and the receiver cannot stall it. The sentinel links live
// in registers and a fill mark stands in for the untouched part of the free
// chain, so the block is ready right after reset with no clearing pass.
module array_linked_list_free_pool
  import allfp_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [VAL_W-1:0]  value_i,
  output logic                     done_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic signed [VAL_W-1:0]  removed_value_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = ((IW > POS_W) ? IW : POS_W) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [IW-1:0]    free_head_q, free_head_d;
  logic [IW:0]      fill_q, fill_d;
  logic [IW-1:0]    anchor_q, anchor_d, fresh_q, fresh_d;

  cmd_t             cmd_q;
  logic [IW-1:0]    pos_idx_q;
  logic             pos_zero_q, in_range_q;
  logic [VAL_W-1:0] value_q;

  logic             done_q, done_d;
  status_t          status_q, status_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [VAL_W-1:0] removed_q, removed_d;

  logic [CW-1:0]    pos_ext_i;
  logic [IW-1:0]    pos_idx_i;
  logic             accept;

  logic             fwd_we, bwd_we, inuse_we, val_we;
  logic [IW-1:0]    fwd_wa, bwd_wa, inuse_wa, val_wa;
  logic [IW-1:0]    fwd_wd, bwd_wd;
  logic             inuse_wd;
  logic [IW-1:0]    fwd_ra, fwd_ra_q;
  logic [IW-1:0]    fwd_rdata, bwd_rdata;
  logic             inuse_rdata;
  logic [VAL_W-1:0] val_rdata;

  logic [IW-1:0]    fwd_rv, bwd_rv, anchor_sel;
  logic             inuse_rv, present, pos_untouched;
  logic             is_ins, is_del, absent;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign pos_ext_i = CW'(position_i);
  assign pos_idx_i = pos_ext_i[IW-1:0];

  allfp_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_fwd_ram (
    .clk_i, .we_i(fwd_we), .waddr_i(fwd_wa), .wdata_i(fwd_wd),
    .raddr_i(fwd_ra), .rdata_o(fwd_rdata)
  );

  allfp_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_bwd_ram (
    .clk_i, .we_i(bwd_we), .waddr_i(bwd_wa), .wdata_i(bwd_wd),
    .raddr_i(pos_idx_i), .rdata_o(bwd_rdata)
  );

  allfp_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_inuse_ram (
    .clk_i, .we_i(inuse_we), .waddr_i(inuse_wa), .wdata_i(inuse_wd),
    .raddr_i(pos_idx_i), .rdata_o(inuse_rdata)
  );

  allfp_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
    .clk_i, .we_i(val_we), .waddr_i(val_wa), .wdata_i(value_q),
    .raddr_i(pos_idx_i), .rdata_o(val_rdata)
  );

  // slots at or above the fill mark still hold their reset links
  always_comb begin
    if (fwd_ra_q == '0) begin
      fwd_rv = head_q;
    end else if ({1'b0, fwd_ra_q} >= fill_q) begin
      fwd_rv = (fwd_ra_q == IW'(SLOTS - 1)) ? '0 : fwd_ra_q + 1'b1;
    end else begin
      fwd_rv = fwd_rdata;
    end
  end

  assign pos_untouched = ({1'b0, pos_idx_q} >= fill_q);
  assign bwd_rv   = pos_zero_q ? tail_q : (pos_untouched ? '0 : bwd_rdata);
  assign inuse_rv = pos_zero_q ? 1'b1 : (pos_untouched ? 1'b0 : inuse_rdata);
  assign present  = in_range_q && inuse_rv;

  assign is_ins = (cmd_q == CMD_AFTER) || (cmd_q == CMD_BEFORE) ||
                  (cmd_q == CMD_HEAD) || (cmd_q == CMD_TAIL);
  assign is_del = (cmd_q == CMD_DEL);
  assign absent = (((cmd_q == CMD_AFTER) || (cmd_q == CMD_BEFORE)) && !present) ||
                  (is_del && (!present || pos_zero_q)) || (!is_ins && !is_del);

  always_comb begin
    case (cmd_q)
      CMD_AFTER:  anchor_sel = pos_idx_q;
      CMD_BEFORE: anchor_sel = bwd_rv;
      CMD_TAIL:   anchor_sel = tail_q;
      default:    anchor_sel = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_head_d = free_head_q;
    fill_d      = fill_q;
    anchor_d    = anchor_q;
    fresh_d     = fresh_q;
    done_d      = 1'b0;
    status_d    = status_q;
    slot_d      = slot_q;
    removed_d   = removed_q;
    fwd_we      = 1'b0;
    fwd_wa      = '0;
    fwd_wd      = '0;
    bwd_we      = 1'b0;
    bwd_wa      = '0;
    bwd_wd      = '0;
    inuse_we    = 1'b0;
    inuse_wa    = '0;
    inuse_wd    = 1'b0;
    val_we      = 1'b0;
    val_wa      = '0;
    fwd_ra      = fwd_ra_q;
    case (state_q)
      S_IDLE: begin
        fwd_ra = (cmd_i == CMD_DEL) ? pos_idx_i : free_head_q;
        if (accept) begin
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        if (absent || (is_ins && (free_head_q == '0))) begin
          done_d    = 1'b1;
          status_d  = absent ? ST_ABSENT : ST_FULL;
          slot_d    = '0;
          removed_d = '0;
          state_d   = S_IDLE;
        end else if (is_ins) begin
          anchor_d    = anchor_sel;
          fresh_d     = free_head_q;
          free_head_d = fwd_rv;
          if ({1'b0, free_head_q} == fill_q) begin
            fill_d = fill_q + 1'b1;
          end
          fwd_ra  = anchor_sel;
          state_d = S_RD2;
        end else begin
          // unlink: prev.fwd = next, next.bwd = prev
          if (bwd_rv == '0) begin
            head_d = fwd_rv;
          end else begin
            fwd_we = 1'b1;
            fwd_wa = bwd_rv;
            fwd_wd = fwd_rv;
          end
          if (fwd_rv == '0) begin
            tail_d = bwd_rv;
          end else begin
            bwd_we = 1'b1;
            bwd_wa = fwd_rv;
            bwd_wd = bwd_rv;
          end
          inuse_we  = 1'b1;
          inuse_wa  = pos_idx_q;
          inuse_wd  = 1'b0;
          removed_d = val_rdata;
          anchor_d  = pos_idx_q;
          state_d   = S_WR;
        end
      end
      S_RD2: begin
        fwd_we = 1'b1;
        fwd_wa = fresh_q;
        fwd_wd = fwd_rv;
        if (fwd_rv == '0) begin
          tail_d = fresh_q;
        end else begin
          bwd_we = 1'b1;
          bwd_wa = fwd_rv;
          bwd_wd = fresh_q;
        end
        inuse_we = 1'b1;
        inuse_wa = fresh_q;
        inuse_wd = 1'b1;
        val_we   = 1'b1;
        val_wa   = fresh_q;
        state_d  = S_WR;
      end
      S_WR: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        state_d  = S_IDLE;
        bwd_we   = 1'b1;
        if (is_ins) begin
          if (anchor_q == '0) begin
            head_d = fresh_q;
          end else begin
            fwd_we = 1'b1;
            fwd_wa = anchor_q;
            fwd_wd = fresh_q;
          end
          bwd_wa    = fresh_q;
          bwd_wd    = anchor_q;
          slot_d    = SLOT_W'(fresh_q);
          removed_d = '0;
        end else begin
          // push the deleted slot onto the free chain
          fwd_we      = 1'b1;
          fwd_wa      = anchor_q;
          fwd_wd      = free_head_q;
          bwd_wa      = anchor_q;
          bwd_wd      = '0;
          free_head_d = anchor_q;
          slot_d      = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_head_q <= IW'(1);
      fill_q      <= (IW+1)'(1);
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      pos_idx_q  <= pos_idx_i;
      pos_zero_q <= (position_i == '0);
      in_range_q <= (pos_ext_i < CW'(SLOTS));
      value_q    <= value_i;
    end
    fwd_ra_q  <= fwd_ra;
    anchor_q  <= anchor_d;
    fresh_q   <= fresh_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
    removed_q <= removed_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign removed_value_o = removed_q;

  // a result beat only follows the end of a command
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result beat while a command is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && (status_o != ST_OK)) |-> ((slot_o == '0) && (removed_value_o == '0)))
    else $error("rejected command carries a slot or value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (fill_q <= (IW+1)'(SLOTS)) && ({1'b0, free_head_q} <= fill_q))
    else $error("free chain head beyond fill mark");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_RD2) |-> ((fresh_q != '0) && (fresh_q != anchor_q)))
    else $error("insert allocates sentinel or anchor slot");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slot array linked list with its free chain.
// Commands are driven through the start/busy handshake with random gaps. A
// scoreboard keeps its own copy of the slot links, the in-use marks and the
// free chain, and predicts status, slot and removed value for every accepted
// command. Each done_o strobe is checked against the oldest prediction. The
// random part runs in phases that lean to filling the pool, lean to draining
// it or mix both, with commands aimed mostly at live slots.
// ----------------------------------------------------------------------------
module tb_top
  import allfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT      = 64;
  localparam int unsigned RAND_BEATS = 1650;
  localparam int unsigned CYCLE_CAP  = 400000;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [VAL_W-1:0]    removed;
  } outcome_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  class list_scoreboard;
    logic [VAL_W-1:0]  val_mem [NSLOT];
    logic [SLOT_W-1:0] fwd [NSLOT];
    logic [SLOT_W-1:0] bwd [NSLOT];
    bit                used [NSLOT];
    logic [SLOT_W-1:0] free_head;
    outcome_t          expected_q [$];
    int                errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      for (int i = 0; i < NSLOT; i++) begin
        fwd[i]     = (i + 1 < NSLOT) ? SLOT_W'(i + 1) : '0;
        bwd[i]     = '0;
        used[i]    = 1'b0;
        val_mem[i] = '0;
      end
      fwd[0]    = '0;
      used[0]   = 1'b1;
      free_head = SLOT_W'(1);
    endfunction

    function outcome_t link_after(logic [SLOT_W-1:0] anchor, logic [VAL_W-1:0] v);
      outcome_t          o;
      logic [SLOT_W-1:0] fresh;
      logic [SLOT_W-1:0] succ;
      o.status  = ST_FULL;
      o.slot    = '0;
      o.removed = '0;
      if (free_head != 0) begin
        fresh          = free_head;
        free_head      = fwd[fresh];
        val_mem[fresh] = v;
        used[fresh]    = 1'b1;
        succ           = fwd[anchor];
        fwd[fresh]     = succ;
        bwd[succ]      = fresh;
        fwd[anchor]    = fresh;
        bwd[fresh]     = anchor;
        o.status       = ST_OK;
        o.slot         = fresh;
      end
      return o;
    endfunction

    function void note(cmd_t c, logic [POS_W-1:0] p, logic [VAL_W-1:0] v);
      outcome_t          o;
      logic [SLOT_W-1:0] prv;
      logic [SLOT_W-1:0] nxt;
      o.status  = ST_ABSENT;
      o.slot    = '0;
      o.removed = '0;
      case (c)
        CMD_AFTER: begin
          if (used[p]) o = link_after(p, v);
        end
        CMD_BEFORE: begin
          if (used[p]) o = link_after(bwd[p], v);
        end
        CMD_HEAD: o = link_after('0, v);
        CMD_TAIL: o = link_after(bwd[0], v);
        CMD_DEL: begin
          if (used[p] && p != 0) begin
            o.status   = ST_OK;
            o.removed  = val_mem[p];
            prv        = bwd[p];
            nxt        = fwd[p];
            fwd[prv]   = nxt;
            bwd[nxt]   = prv;
            fwd[p]     = free_head;
            bwd[p]     = '0;
            used[p]    = 1'b0;
            val_mem[p] = '0;
            free_head  = p;
          end
        end
        default: ;
      endcase
      expected_q.push_back(o);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check(status_t st, logic [SLOT_W-1:0] sl, logic [VAL_W-1:0] rv);
      outcome_t o;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d slot %0d", st, sl));
      end else begin
        o = expected_q.pop_front();
        if (st !== o.status)
          report($sformatf("status got %0d want %0d", st, o.status));
        if (sl !== o.slot)
          report($sformatf("slot got %0d want %0d", sl, o.slot));
        if (rv !== o.removed)
          report($sformatf("removed value got %h want %h", rv, o.removed));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function logic [SLOT_W-1:0] pick_live(bit with_sentinel);
      int live [$];
      for (int i = 0; i < NSLOT; i++)
        if (used[i] && (with_sentinel || i != 0)) live.push_back(i);
      if (live.size() == 0) return '0;
      return SLOT_W'(live[$urandom_range(live.size() - 1)]);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  cmd_i;
  logic [POS_W-1:0]  position_i;
  logic [VAL_W-1:0]  value_i;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [SLOT_W-1:0] slot_o;
  logic [VAL_W-1:0]  removed_value_o;

  list_scoreboard sb = new();
  int unsigned    cycles = 0;
  bit             no_gaps = 1'b0;

  array_linked_list_free_pool #(.SLOTS(NSLOT)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .removed_value_o (removed_value_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(status_o, slot_o, removed_value_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one command beat, sent after a random gap unless no_gaps is set
  task send(cmd_t c, logic [POS_W-1:0] p, logic [VAL_W-1:0] v);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(8));
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start      <= 1'b1;
    cmd_i      <= c;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (busy);
    sb.note(c, p, v);
  endtask

  task hold_off();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function logic [VAL_W-1:0] draw_value();
    case ($urandom_range(11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task random_beat(int ins_pct);
    cmd_t              c;
    logic [POS_W-1:0]  p;
    if ($urandom_range(99) < 8) begin
      c = cmd_t'($urandom_range(7));
      p = POS_W'($urandom_range(63));
    end else if ($urandom_range(99) < ins_pct) begin
      case ($urandom_range(3))
        0: c = CMD_AFTER;
        1: c = CMD_BEFORE;
        2: c = CMD_HEAD;
        default: c = CMD_TAIL;
      endcase
      if (c == CMD_AFTER || c == CMD_BEFORE) p = sb.pick_live(1'b1);
      else p = POS_W'($urandom_range(63));
    end else begin
      c = CMD_DEL;
      p = sb.pick_live(1'b0);
    end
    send(c, p, draw_value());
  endtask

  initial begin
    int     sent;
    int     len;
    int     waited;
    phase_e ph;
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_i      = CMD_AFTER;
    position_i = '0;
    value_i    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // rejected commands on an empty list
    send(CMD_DEL, 6'd0, 32'h0);
    send(CMD_DEL, 6'd5, 32'h0);
    send(CMD_AFTER, 6'd63, 32'hffff_ffff);
    send(CMD_BEFORE, 6'd1, 32'h1234_5678);
    send(cmd_t'(5), 6'd63, 32'hffff_ffff);
    send(cmd_t'(6), 6'd42, 32'h0);
    send(cmd_t'(7), 6'd21, 32'h8000_0000);
    // inserts from every side
    send(CMD_HEAD, 6'd63, 32'h7fff_ffff);
    send(CMD_TAIL, 6'd42, 32'h8000_0000);
    send(CMD_AFTER, 6'd1, 32'hffff_ffff);
    send(CMD_BEFORE, 6'd1, 32'h0);
    send(CMD_AFTER, 6'd0, 32'h5a5a_5a5a);
    send(CMD_BEFORE, 6'd0, 32'ha5a5_a5a5);
    send(CMD_BEFORE, 6'd2, 32'h0000_0001);
    // deletes, a second delete of a freed slot, reuse of the freed slot
    send(CMD_DEL, 6'd2, 32'h0);
    send(CMD_DEL, 6'd1, 32'h0);
    send(CMD_DEL, 6'd3, 32'hffff_ffff);
    send(CMD_DEL, 6'd2, 32'h0);
    send(CMD_AFTER, 6'd3, 32'h0);
    send(CMD_HEAD, 6'd0, 32'hdead_beef);
    send(CMD_TAIL, 6'd0, 32'h0bad_f00d);
    send(CMD_DEL, 6'd63, 32'h0);
    hold_off();

    sent = 0;
    ph   = PH_FILL;
    len  = 150;
    while (sent < RAND_BEATS) begin
      no_gaps = ($urandom_range(3) == 0);
      for (int i = 0; i < len; i++) begin
        case (ph)
          PH_FILL:  random_beat(90);
          PH_DRAIN: random_beat(10);
          default:  random_beat(50);
        endcase
        sent++;
      end
      if (sent == 150 || $urandom_range(4) == 0) hold_off();
      if (sent == 150) begin
        ph  = PH_DRAIN;
        len = 150;
      end else begin
        case ($urandom_range(2))
          0: ph = PH_FILL;
          1: ph = PH_DRAIN;
          default: ph = PH_MIX;
        endcase
        len = int'($urandom_range(30, 120));
      end
    end

    @(negedge clk_i);
    start  <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (16) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
